// File: rtl/core/gpa_pkg.sv
package gpa_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        KIND_XOR = 2'd0,
        KIND_MUL = 2'd1,
        KIND_REM = 2'd2,
        KIND_QUO = 2'd3
    } t_kind;

    // Control that travels down the pipeline next to the data
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_ctl;

    localparam int OPND_W     = 32;
    localparam int USER_W     = 2;
    localparam int DATA_IN_W  = 2 * OPND_W;
    localparam int RES_W      = 63;
    localparam int DATA_OUT_W = 64;

endpackage

// File: rtl/core/gpa_entry.sv
module gpa_entry #(
    parameter int WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_valid,
    input  gpa_pkg::t_kind             i_kind,
    input  logic [gpa_pkg::OPND_W-1:0] i_first,
    input  logic [gpa_pkg::OPND_W-1:0] i_second,
    output gpa_pkg::t_ctl              o_ctl,
    output logic [WIDTH-1:0]           o_a,
    output logic [WIDTH-1:0]           o_b,
    output logic [WIDTH-1:0]           o_lead,
    output logic [2*WIDTH-2:0]         o_acc,
    output logic [WIDTH-1:0]           o_q
);
    import gpa_pkg::*;

    localparam int ACC_W = 2 * WIDTH - 1;

    t_ctl               r_ctl;
    logic [WIDTH-1:0]   r_a, r_b, r_lead;
    logic [ACC_W-1:0]   r_acc;
    logic [WIDTH-1:0]   n_lead;
    logic [ACC_W-1:0]   n_acc;
    logic [WIDTH-1:0]   w_a, w_b;

    // Keep only the low WIDTH coefficients
    assign w_a = i_first[WIDTH-1:0];
    assign w_b = i_second[WIDTH-1:0];

    // Isolate the divisor's leading term: smear ones downward, keep the top one
    always_comb begin
        logic [WIDTH-1:0] smear;
        smear = w_b;
        for (int sh = 1; sh < WIDTH; sh = sh * 2) begin
            smear = smear | (smear >> sh);
        end
        n_lead = smear & ~(smear >> 1);
    end

    // Seed the accumulator: xor result, empty product, or the dividend
    always_comb begin
        case (i_kind)
            KIND_XOR: n_acc = ACC_W'(w_a ^ w_b);
            KIND_MUL: n_acc = '0;
            default:  n_acc = ACC_W'(w_a);
        endcase
    end

    // Capture a beat whenever the pipeline advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl.kind <= i_kind;
            r_a        <= w_a;
            r_b        <= w_b;
            r_lead     <= n_lead;
            r_acc      <= n_acc;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_lead = r_lead;
    assign o_acc  = r_acc;
    assign o_q    = '0;

    a_lead_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid |-> $onehot0(r_lead))
        else $error("leading-term mask has more than one bit");

    a_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid |-> ((r_lead == '0) == (r_b == '0)))
        else $error("leading-term mask disagrees with divisor being zero");

endmodule

// File: rtl/core/gpa_step.sv
module gpa_step #(
    parameter int WIDTH = 32,
    parameter int STEP  = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  gpa_pkg::t_ctl      i_ctl,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    input  logic [WIDTH-1:0]   i_lead,
    input  logic [2*WIDTH-2:0] i_acc,
    input  logic [WIDTH-1:0]   i_q,
    output gpa_pkg::t_ctl      o_ctl,
    output logic [WIDTH-1:0]   o_a,
    output logic [WIDTH-1:0]   o_b,
    output logic [WIDTH-1:0]   o_lead,
    output logic [2*WIDTH-2:0] o_acc,
    output logic [WIDTH-1:0]   o_q
);
    import gpa_pkg::*;

    localparam int ACC_W = 2 * WIDTH - 1;
    // Divisor shift handled here: steps walk from the top degree down
    localparam int SHIFT = WIDTH - 1 - STEP;

    t_ctl             r_ctl;
    logic [WIDTH-1:0] r_a, r_b, r_lead, r_q;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [WIDTH-1:0] n_q;
    logic [ACC_W-1:0] w_pp;
    logic [WIDTH-1:0] w_den, w_hit, w_hit_done;

    // Partial product for multiplier bit STEP, shifted divisor and its lead
    assign w_pp       = ACC_W'(i_a) << STEP;
    assign w_den      = i_b << SHIFT;
    assign w_hit      = i_lead << SHIFT;
    assign w_hit_done = r_lead << SHIFT;

    // One multiply bit or one division step; xor passes through unchanged
    always_comb begin
        n_acc = i_acc;
        n_q   = i_q;
        case (i_ctl.kind)
            KIND_MUL: begin
                if (i_b[STEP]) begin
                    n_acc = i_acc ^ w_pp;
                end
            end
            KIND_REM, KIND_QUO: begin
                if (|(i_acc[WIDTH-1:0] & w_hit)) begin
                    n_acc[WIDTH-1:0] = i_acc[WIDTH-1:0] ^ w_den;
                    n_q[SHIFT]       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance the stage with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl.kind <= i_ctl.kind;
            r_a        <= i_a;
            r_b        <= i_b;
            r_lead     <= i_lead;
            r_acc      <= n_acc;
            r_q        <= n_q;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_lead = r_lead;
    assign o_acc  = r_acc;
    assign o_q    = r_q;

    a_term_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.valid && (r_ctl.kind == KIND_REM || r_ctl.kind == KIND_QUO))
        |-> ((r_acc[WIDTH-1:0] & w_hit_done) == '0))
        else $error("division step left the aligned leading term set");

endmodule

// File: rtl/core/gpa_out.sv
module gpa_out #(
    parameter int WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  gpa_pkg::t_ctl                  i_ctl,
    input  logic [WIDTH-1:0]               i_lead,
    input  logic [2*WIDTH-2:0]             i_acc,
    input  logic [WIDTH-1:0]               i_q,
    output logic                           o_valid,
    output logic [gpa_pkg::DATA_OUT_W-1:0] o_data
);
    import gpa_pkg::*;

    logic                  r_valid;
    logic [RES_W-1:0]      r_res;
    logic                  r_dbz;
    logic [RES_W-1:0]      n_res;
    logic                  n_dbz;
    logic                  w_zero_div;

    assign w_zero_div = (i_lead == '0);

    // Pick the result for the operation; a zero divisor flags an error for remainder and quotient
    always_comb begin
        n_dbz = 1'b0;
        case (i_ctl.kind)
            KIND_REM: begin
                n_res = w_zero_div ? '0 : RES_W'(i_acc[WIDTH-1:0]);
                n_dbz = w_zero_div;
            end
            KIND_QUO: begin
                n_res = w_zero_div ? '0 : RES_W'(i_q);
                n_dbz = w_zero_div;
            end
            default: n_res = RES_W'(i_acc);
        endcase
    end

    // Output register; hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
            r_dbz <= n_dbz;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_dbz, r_res};

endmodule

// File: rtl/core/gf2_poly_arith_unit.sv
// Channel  Dir  tdata (low bit up)                           tuser
// s_axis   in   first_poly[31:0], second_poly[63:32]         kind[1:0]
// m_axis   out  result_poly[62:0], divide_by_zero[63]        -
//
// One item per cycle while m_axis is not stalled; the path is an entry register,
// WIDTH step stages (one multiplier bit or one division step each), and
// the output register.
// Reset clears all valid bits; payload registers are left as they are.
// A stall at m_axis freezes every stage together, so nothing is dropped
// or repeated; s_axis is ready whenever the output register is empty or
// being drained.
module gf2_poly_arith_unit #(
    parameter int WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // first_poly[31:0], second_poly[63:32]
    input  logic [gpa_pkg::DATA_IN_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  logic [gpa_pkg::USER_W-1:0]     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // result_poly[62:0], divide_by_zero[63]
    output logic [gpa_pkg::DATA_OUT_W-1:0] o_m_tdata
);
    import gpa_pkg::*;

    localparam int ACC_W = 2 * WIDTH - 1;

    logic             w_adv;
    t_ctl             w_ctl  [0:WIDTH];
    logic [WIDTH-1:0] w_a    [0:WIDTH];
    logic [WIDTH-1:0] w_b    [0:WIDTH];
    logic [WIDTH-1:0] w_lead [0:WIDTH];
    logic [ACC_W-1:0] w_acc  [0:WIDTH];
    logic [WIDTH-1:0] w_q    [0:WIDTH];

    // Whole pipeline moves unless the output beat is stalled
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    gpa_entry #(.WIDTH(WIDTH)) u_entry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_s_tvalid),
        .i_kind   (t_kind'(i_s_tuser)),
        .i_first  (i_s_tdata[OPND_W-1:0]),
        .i_second (i_s_tdata[DATA_IN_W-1:OPND_W]),
        .o_ctl    (w_ctl[0]),
        .o_a      (w_a[0]),
        .o_b      (w_b[0]),
        .o_lead   (w_lead[0]),
        .o_acc    (w_acc[0]),
        .o_q      (w_q[0])
    );

    // One stage per coefficient
    for (genvar k = 0; k < WIDTH; k++) begin : g_step
        gpa_step #(.WIDTH(WIDTH), .STEP(k)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_ctl[k]),
            .i_a     (w_a[k]),
            .i_b     (w_b[k]),
            .i_lead  (w_lead[k]),
            .i_acc   (w_acc[k]),
            .i_q     (w_q[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_a     (w_a[k+1]),
            .o_b     (w_b[k+1]),
            .o_lead  (w_lead[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_q     (w_q[k+1])
        );
    end

    gpa_out #(.WIDTH(WIDTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_ctl[WIDTH]),
        .i_lead  (w_lead[WIDTH]),
        .i_acc   (w_acc[WIDTH]),
        .i_q     (w_q[WIDTH]),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata)
    );

endmodule

// File: tb/testbench.sv
module testbench;
    import gpa_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 6;
    localparam int DRAIN_WAIT  = OPND_W + 8;
    localparam int CYCLE_LIMIT = 200000;

    // Expected result of one operand pair
    typedef struct {
        logic [RES_W-1:0] poly;
        logic             dz;
    } t_gf2_result;

    // Predicts the unit's results and holds them in arrival order
    class gf2_result_board;
        t_gf2_result pending_results[$];
        int unsigned mismatches;

        // Carry-less product of two polynomials
        function logic [RES_W-1:0] clmul_poly(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
            logic [RES_W-1:0] acc;
            acc = '0;
            for (int i = 0; i < OPND_W; i++) begin
                if (b[i]) begin
                    acc ^= {{(RES_W-OPND_W){1'b0}}, a} << i;
                end
            end
            return acc;
        endfunction

        // Long division from the top degree down; den is nonzero
        function void divide_poly(logic [OPND_W-1:0] num, logic [OPND_W-1:0] den,
                                  output logic [OPND_W-1:0] quo,
                                  output logic [OPND_W-1:0] rem);
            int top_deg;
            top_deg = 0;
            for (int i = 0; i < OPND_W; i++) begin
                if (den[i]) top_deg = i;
            end
            quo = '0;
            rem = num;
            for (int i = OPND_W - 1; i >= top_deg; i--) begin
                if (rem[i]) begin
                    rem ^= den << (i - top_deg);
                    quo[i - top_deg] = 1'b1;
                end
            end
        endfunction

        function t_gf2_result predict_result(t_kind kind, logic [OPND_W-1:0] a,
                                             logic [OPND_W-1:0] b);
            t_gf2_result res;
            logic [OPND_W-1:0] quo;
            logic [OPND_W-1:0] rem;
            res.poly = '0;
            res.dz   = 1'b0;
            case (kind)
                KIND_XOR: res.poly = {{(RES_W-OPND_W){1'b0}}, a ^ b};
                KIND_MUL: res.poly = clmul_poly(a, b);
                KIND_REM, KIND_QUO: begin
                    if (b == '0) begin
                        res.dz = 1'b1;
                    end else begin
                        divide_poly(a, b, quo, rem);
                        res.poly = {{(RES_W-OPND_W){1'b0}}, (kind == KIND_REM) ? rem : quo};
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_operands(t_kind kind, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
            pending_results.insert(pending_results.size(), predict_result(kind, a, b));
        endfunction

        function void check_result(logic [DATA_OUT_W-1:0] beat);
            t_gf2_result want;
            if (pending_results.size() == 0) begin
                $error("result_poly: unexpected beat, actual %h", beat[RES_W-1:0]);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (beat[RES_W-1:0] !== want.poly) begin
                $error("result_poly: expected %h, actual %h", want.poly, beat[RES_W-1:0]);
                mismatches++;
            end
            if (beat[RES_W] !== want.dz) begin
                $error("divide_by_zero: expected %b, actual %b", want.dz, beat[RES_W]);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // first_poly[31:0], second_poly[63:32]
    logic [DATA_IN_W-1:0]  i_s_tdata  = '0;
    // kind[1:0]
    logic [USER_W-1:0]     i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // result_poly[62:0], divide_by_zero[63]
    logic [DATA_OUT_W-1:0] o_m_tdata;

    gf2_result_board board = new;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int unsigned     cycle_count   = 0;

    gf2_poly_arith_unit #(
        .WIDTH (OPND_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Free-running clock
    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check output beats and throttle tready
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                board.check_result(o_m_tdata);
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Present one operand pair, idling at random first, and hold until accepted
    task automatic push_op(input t_kind kind, input logic [OPND_W-1:0] a,
                           input logic [OPND_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        board.note_operands(kind, a, b);
    endtask

    // Drop valid and hold until every expected result has come
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random polynomial of random degree, zero now and then
    function automatic logic [OPND_W-1:0] rand_poly(int zero_pct);
        int top_deg;
        top_deg = $urandom_range(OPND_W - 1);
        if ($urandom_range(99) < zero_pct) return '0;
        return $urandom & ({OPND_W{1'b1}} >> (OPND_W - 1 - top_deg));
    endfunction

    task automatic run_random(input int count);
        t_kind kind;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        for (int n = 0; n < count; n++) begin
            kind = t_kind'($urandom_range(3));
            if ($urandom_range(3) == 0) begin
                a = $urandom;
                b = $urandom;
            end else begin
                a = rand_poly(4);
                b = rand_poly(8);
            end
            push_op(kind, a, b);
        end
    endtask

    // Stimulus
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 71;

        // Field extremes for xor and multiply
        push_op(KIND_XOR, 32'h0000_0000, 32'h0000_0000);
        push_op(KIND_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(KIND_XOR, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
        push_op(KIND_MUL, 32'hDEAD_BEEF, 32'h0000_0001);
        // Zero second operand never flags for xor or multiply
        push_op(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(KIND_XOR, 32'h1234_5678, 32'h0000_0000);
        // Zero divisor
        push_op(KIND_REM, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(KIND_QUO, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(KIND_QUO, 32'h0000_0000, 32'h0000_0000);
        // Unit divisor
        push_op(KIND_REM, 32'hFFFF_FFFF, 32'h0000_0001);
        push_op(KIND_QUO, 32'hFFFF_FFFF, 32'h0000_0001);
        // Dividend degree below divisor degree
        push_op(KIND_REM, 32'h0000_00A5, 32'h0000_0100);
        push_op(KIND_QUO, 32'h0000_00A5, 32'h0000_0100);
        push_op(KIND_REM, 32'h7FFF_FFFF, 32'h8000_0000);
        // Top-degree divisors, high dividends and a zero dividend
        push_op(KIND_REM, 32'hFFFF_FFFF, 32'h8000_0000);
        push_op(KIND_QUO, 32'hFFFF_FFFF, 32'h8000_0000);
        push_op(KIND_QUO, 32'h8000_0000, 32'h0000_0003);
        push_op(KIND_REM, 32'h8000_0000, 32'h0000_0003);
        push_op(KIND_QUO, 32'hC0FF_EE11, 32'hC0FF_EE11);
        push_op(KIND_REM, 32'h0000_0000, 32'hFFFF_FFFF);

        // Let the pipeline empty before the random part
        drain_results();

        run_random(130);

        send_idle_pct = 71;
        recv_idle_pct = 16;
        run_random(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(140);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
